/* rtl/core/tnt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tnt_pkg
// Shared types, constants and operand tables of the triangle normal/tangent
// block.
// ----------------------------------------------------------------------------
package tnt_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned NUM_OPS         = 10;
  localparam int unsigned OP_IDX_W        = 4;
  localparam int unsigned MUL_W           = 30;
  localparam int unsigned NORM_W          = 30;
  localparam int unsigned SQ_W            = 2 * NORM_W + 2;
  localparam int unsigned LEN_W           = 32;
  localparam int unsigned DIV_W           = 48;
  localparam int unsigned FRAC_W          = 14;
  localparam int unsigned QUO_W           = FRAC_W + 1;
  localparam logic signed [15:0] Q14_ONE  = 16'sd16384;

  // operand slots of a job
  localparam logic [OP_IDX_W-1:0] OP_E1X = 4'd0;
  localparam logic [OP_IDX_W-1:0] OP_E1Y = 4'd1;
  localparam logic [OP_IDX_W-1:0] OP_E1Z = 4'd2;
  localparam logic [OP_IDX_W-1:0] OP_E2X = 4'd3;
  localparam logic [OP_IDX_W-1:0] OP_E2Y = 4'd4;
  localparam logic [OP_IDX_W-1:0] OP_E2Z = 4'd5;
  localparam logic [OP_IDX_W-1:0] OP_DU1 = 4'd6;
  localparam logic [OP_IDX_W-1:0] OP_DV1 = 4'd7;
  localparam logic [OP_IDX_W-1:0] OP_DU2 = 4'd8;
  localparam logic [OP_IDX_W-1:0] OP_DV2 = 4'd9;

  // cross terms a*b - c*d, in evaluation order
  typedef enum logic [3:0] {
    TERM_NX, TERM_NY, TERM_NZ, TERM_DET,
    TERM_TX, TERM_TY, TERM_TZ,
    TERM_BX, TERM_BY, TERM_BZ
  } term_e;

  typedef enum logic [1:0] {
    VEC_NORMAL, VEC_TANGENT, VEC_BITANGENT
  } vec_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD_A, ST_LOAD_B, ST_MUL, ST_ACC, ST_STORE,
    ST_ABS, ST_SHIFT, ST_SQ_MUL, ST_SQ_ACC, ST_SQRT,
    ST_DIV_INIT, ST_DIV, ST_DIV_END, ST_UNIT, ST_OUT
  } back_state_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic               has_uv;
  } vertex_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] bitangent_x;
    logic signed [15:0] bitangent_y;
    logic signed [15:0] bitangent_z;
    logic               tangent_valid;
  } basis_t;

  // slot 0..3 selects a, b, c, d of the term
  function automatic logic [OP_IDX_W-1:0] term_op(term_e term, logic [1:0] slot);
    logic [OP_IDX_W-1:0] a, b, c, d;
    a = OP_E1X; b = OP_E1X; c = OP_E1X; d = OP_E1X;
    case (term)
      TERM_NX:  begin a = OP_E1Y; b = OP_E2Z; c = OP_E1Z; d = OP_E2Y; end
      TERM_NY:  begin a = OP_E1Z; b = OP_E2X; c = OP_E1X; d = OP_E2Z; end
      TERM_NZ:  begin a = OP_E1X; b = OP_E2Y; c = OP_E1Y; d = OP_E2X; end
      TERM_DET: begin a = OP_DU1; b = OP_DV2; c = OP_DU2; d = OP_DV1; end
      TERM_TX:  begin a = OP_E1X; b = OP_DV2; c = OP_E2X; d = OP_DV1; end
      TERM_TY:  begin a = OP_E1Y; b = OP_DV2; c = OP_E2Y; d = OP_DV1; end
      TERM_TZ:  begin a = OP_E1Z; b = OP_DV2; c = OP_E2Z; d = OP_DV1; end
      TERM_BX:  begin a = OP_E2X; b = OP_DU1; c = OP_E1X; d = OP_DU2; end
      TERM_BY:  begin a = OP_E2Y; b = OP_DU1; c = OP_E1Y; d = OP_DU2; end
      TERM_BZ:  begin a = OP_E2Z; b = OP_DU1; c = OP_E1Z; d = OP_DU2; end
      default:  begin a = OP_E1X; end
    endcase
    case (slot)
      2'd0:    term_op = a;
      2'd1:    term_op = b;
      2'd2:    term_op = c;
      default: term_op = d;
    endcase
  endfunction

endpackage
`default_nettype wire

/* rtl/core/tnt_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tnt_queue
// Small job queue between the vertex front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module tnt_queue #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = tnt_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [Width-1:0]      pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/tnt_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tnt_front
// Vertex front end: holds the first two vertices and forms the edge and UV
// deltas of each completed triangle as one job.
// ----------------------------------------------------------------------------
module tnt_front #(
  parameter int unsigned CoordWidth = tnt_pkg::COORD_WIDTH_DEF,
  localparam int unsigned OpW       = CoordWidth + 1
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      in_valid_i,
  output logic                                           in_ready_o,
  input  wire tnt_pkg::vertex_t                          in_data_i,
  input  wire logic                                      tangents_enable_i,
  output logic                                           job_valid_o,
  input  wire logic                                      job_ready_i,
  output logic [tnt_pkg::NUM_OPS-1:0][OpW-1:0]           job_ops_o,
  output logic                                           job_tan_o
);

  logic [1:0]                  count_q;
  logic signed [CoordWidth-1:0] pos_q [2][3];
  logic signed [CoordWidth-1:0] uv_q  [2][2];
  logic signed [CoordWidth-1:0] x, y, z, u, v;
  logic                        accept, third;

  assign x = CoordWidth'(in_data_i.pos_x);
  assign y = CoordWidth'(in_data_i.pos_y);
  assign z = CoordWidth'(in_data_i.pos_z);
  assign u = CoordWidth'(in_data_i.tex_u);
  assign v = CoordWidth'(in_data_i.tex_v);

  assign third       = (count_q == 2'd2);
  assign in_ready_o  = !third || job_ready_i;
  assign job_valid_o = in_valid_i && third;
  assign accept      = in_valid_i && in_ready_o;
  assign job_tan_o   = tangents_enable_i && in_data_i.has_uv;

  always_comb begin
    job_ops_o[tnt_pkg::OP_E1X] = OpW'(pos_q[1][0]) - OpW'(pos_q[0][0]);
    job_ops_o[tnt_pkg::OP_E1Y] = OpW'(pos_q[1][1]) - OpW'(pos_q[0][1]);
    job_ops_o[tnt_pkg::OP_E1Z] = OpW'(pos_q[1][2]) - OpW'(pos_q[0][2]);
    job_ops_o[tnt_pkg::OP_E2X] = OpW'(x) - OpW'(pos_q[0][0]);
    job_ops_o[tnt_pkg::OP_E2Y] = OpW'(y) - OpW'(pos_q[0][1]);
    job_ops_o[tnt_pkg::OP_E2Z] = OpW'(z) - OpW'(pos_q[0][2]);
    job_ops_o[tnt_pkg::OP_DU1] = OpW'(uv_q[1][0]) - OpW'(uv_q[0][0]);
    job_ops_o[tnt_pkg::OP_DV1] = OpW'(uv_q[1][1]) - OpW'(uv_q[0][1]);
    job_ops_o[tnt_pkg::OP_DU2] = OpW'(u) - OpW'(uv_q[0][0]);
    job_ops_o[tnt_pkg::OP_DV2] = OpW'(v) - OpW'(uv_q[0][1]);
  end

  always_ff @(posedge clk_i) begin
    if (accept && !third) begin
      pos_q[count_q[0]][0] <= x;
      pos_q[count_q[0]][1] <= y;
      pos_q[count_q[0]][2] <= z;
      uv_q[count_q[0]][0]  <= u;
      uv_q[count_q[0]][1]  <= v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else if (accept) begin
      count_q <= third ? 2'd0 : count_q + 2'd1;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/tnt_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tnt_back
// Arithmetic back end: cross terms on a shared multiplier, then scaling to
// unit length with a bit-serial square root and divider.
// ----------------------------------------------------------------------------
module tnt_back #(
  parameter int unsigned CoordWidth = tnt_pkg::COORD_WIDTH_DEF,
  localparam int unsigned OpW       = CoordWidth + 1
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                job_valid_i,
  output logic                                     job_ready_o,
  input  wire logic [tnt_pkg::NUM_OPS-1:0][OpW-1:0] job_ops_i,
  input  wire logic                                job_tan_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output tnt_pkg::basis_t                          out_data_o
);

  localparam int unsigned HalfW = (CoordWidth + 1) / 2;
  localparam int unsigned AccW  = 2 * CoordWidth + 2;

  tnt_pkg::back_state_e state_q, state_d;

  logic [tnt_pkg::NUM_OPS-1:0][OpW-1:0] ops_q;
  logic                          tan_q, neg_q, pneg_q, prod_q;
  tnt_pkg::term_e                term_q;
  tnt_pkg::vec_e                 vec_q;
  logic [1:0]                    part_q, comp_q;
  logic [2*HalfW-1:0]            mag_a_q, mag_b_q;
  logic                          sign_a_q;
  logic [2*tnt_pkg::MUL_W-1:0]   mul_q;
  logic signed [AccW-1:0]        acc_q;
  logic [2:0][AccW-1:0]          cv_q, m_q;
  logic [2:0]                    sg_q;
  logic [tnt_pkg::SQ_W-1:0]      n_q, res_q, bit_q, len2_q;
  logic [tnt_pkg::DIV_W-1:0]     rem_q;
  logic [tnt_pkg::LEN_W:0]       den_q;
  logic [tnt_pkg::QUO_W-1:0]     quo_q;
  logic [3:0]                    iter_q;
  logic [2:0][15:0]              uq_q;
  tnt_pkg::basis_t               basis_q, out_q;
  logic                          out_valid_q;

  logic [OpW-1:0]                op_sel, op_abs;
  logic [tnt_pkg::MUL_W-1:0]     mul_a, mul_b;
  logic [AccW-1:0]               pp, or_m;
  logic [tnt_pkg::NORM_W-1:0]    vsel;
  logic [tnt_pkg::SQ_W-1:0]      rt_trial;
  logic [tnt_pkg::DIV_W-1:0]     dv_trial;
  logic [15:0]                   q_signed;
  logic                          out_load, is_tb;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign is_tb       = (term_q >= tnt_pkg::TERM_TX);

  always_comb begin
    op_sel = ops_q[tnt_pkg::term_op(term_q, {prod_q, (state_q == tnt_pkg::ST_LOAD_B)})];
    op_abs = op_sel[OpW-1] ? (~op_sel + 1'b1) : op_sel;
  end

  assign vsel = m_q[comp_q][tnt_pkg::NORM_W-1:0];

  always_comb begin
    if (state_q == tnt_pkg::ST_SQ_MUL) begin
      mul_a = vsel;
      mul_b = vsel;
    end else begin
      mul_a = tnt_pkg::MUL_W'(part_q[1] ? mag_a_q[2*HalfW-1:HalfW] : mag_a_q[HalfW-1:0]);
      mul_b = tnt_pkg::MUL_W'(part_q[0] ? mag_b_q[2*HalfW-1:HalfW] : mag_b_q[HalfW-1:0]);
    end
  end

  always_comb begin
    pp = AccW'(mul_q[2*HalfW-1:0]);
    case (part_q)
      2'd0:    pp = pp;
      2'd3:    pp = pp << (2 * HalfW);
      default: pp = pp << HalfW;
    endcase
  end

  assign or_m     = m_q[0] | m_q[1] | m_q[2];
  assign rt_trial = res_q + bit_q;
  assign dv_trial = tnt_pkg::DIV_W'(den_q) << iter_q;
  assign q_signed = sg_q[comp_q] ? (16'd0 - 16'(quo_q)) : 16'(quo_q);

  always_comb begin
    state_d     = state_q;
    job_ready_o = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      tnt_pkg::ST_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) state_d = tnt_pkg::ST_LOAD_A;
      end
      tnt_pkg::ST_LOAD_A: state_d = tnt_pkg::ST_LOAD_B;
      tnt_pkg::ST_LOAD_B: state_d = tnt_pkg::ST_MUL;
      tnt_pkg::ST_MUL:    state_d = tnt_pkg::ST_ACC;
      tnt_pkg::ST_ACC: begin
        if (part_q != 2'd3)  state_d = tnt_pkg::ST_MUL;
        else if (!prod_q)    state_d = tnt_pkg::ST_LOAD_A;
        else                 state_d = tnt_pkg::ST_STORE;
      end
      tnt_pkg::ST_STORE: begin
        if (term_q == tnt_pkg::TERM_DET) begin
          state_d = (acc_q == '0) ? tnt_pkg::ST_OUT : tnt_pkg::ST_LOAD_A;
        end else begin
          state_d = (comp_q == 2'd2) ? tnt_pkg::ST_ABS : tnt_pkg::ST_LOAD_A;
        end
      end
      tnt_pkg::ST_ABS: begin
        state_d = ((cv_q[0] | cv_q[1] | cv_q[2]) == '0) ? tnt_pkg::ST_UNIT
                                                          : tnt_pkg::ST_SHIFT;
      end
      tnt_pkg::ST_SHIFT: begin
        if ((or_m >> tnt_pkg::NORM_W) == '0 && or_m[tnt_pkg::NORM_W-1]) begin
          state_d = tnt_pkg::ST_SQ_MUL;
        end
      end
      tnt_pkg::ST_SQ_MUL: state_d = tnt_pkg::ST_SQ_ACC;
      tnt_pkg::ST_SQ_ACC: begin
        state_d = (comp_q == 2'd2) ? tnt_pkg::ST_SQRT : tnt_pkg::ST_SQ_MUL;
      end
      tnt_pkg::ST_SQRT: begin
        if (bit_q[0]) state_d = tnt_pkg::ST_DIV_INIT;
      end
      tnt_pkg::ST_DIV_INIT: state_d = tnt_pkg::ST_DIV;
      tnt_pkg::ST_DIV: begin
        if (iter_q == 4'd0) state_d = tnt_pkg::ST_DIV_END;
      end
      tnt_pkg::ST_DIV_END: begin
        state_d = (comp_q == 2'd2) ? tnt_pkg::ST_UNIT : tnt_pkg::ST_DIV_INIT;
      end
      tnt_pkg::ST_UNIT: begin
        if (vec_q == tnt_pkg::VEC_NORMAL && !tan_q) state_d = tnt_pkg::ST_OUT;
        else if (vec_q == tnt_pkg::VEC_BITANGENT)   state_d = tnt_pkg::ST_OUT;
        else                                        state_d = tnt_pkg::ST_LOAD_A;
      end
      tnt_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = tnt_pkg::ST_IDLE;
        end
      end
      default: state_d = tnt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tnt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= basis_q;
    case (state_q)
      tnt_pkg::ST_IDLE: begin
        ops_q                 <= job_ops_i;
        tan_q                 <= job_tan_i;
        term_q                <= tnt_pkg::TERM_NX;
        vec_q                 <= tnt_pkg::VEC_NORMAL;
        comp_q                <= 2'd0;
        prod_q                <= 1'b0;
        part_q                <= 2'd0;
        neg_q                 <= 1'b0;
        acc_q                 <= '0;
        basis_q               <= '{normal_x: 16'sd0, normal_y: 16'sd0, normal_z: 16'sd0,
                                   tangent_x: tnt_pkg::Q14_ONE, tangent_y: 16'sd0,
                                   tangent_z: 16'sd0, bitangent_x: 16'sd0,
                                   bitangent_y: tnt_pkg::Q14_ONE, bitangent_z: 16'sd0,
                                   tangent_valid: 1'b0};
      end
      tnt_pkg::ST_LOAD_A: begin
        mag_a_q  <= (2*HalfW)'(op_abs[CoordWidth-1:0]);
        sign_a_q <= op_sel[OpW-1];
      end
      tnt_pkg::ST_LOAD_B: begin
        mag_b_q <= (2*HalfW)'(op_abs[CoordWidth-1:0]);
        pneg_q  <= sign_a_q ^ op_sel[OpW-1] ^ prod_q ^ (neg_q & is_tb);
      end
      tnt_pkg::ST_MUL: begin
        mul_q <= mul_a * mul_b;
      end
      tnt_pkg::ST_ACC: begin
        acc_q  <= pneg_q ? acc_q - signed'(pp) : acc_q + signed'(pp);
        part_q <= part_q + 2'd1;
        if (part_q == 2'd3) prod_q <= 1'b1;
      end
      tnt_pkg::ST_STORE: begin
        acc_q  <= '0;
        prod_q <= 1'b0;
        if (term_q == tnt_pkg::TERM_DET) begin
          neg_q  <= acc_q[AccW-1];
          term_q <= tnt_pkg::TERM_TX;
          vec_q  <= tnt_pkg::VEC_TANGENT;
          comp_q <= 2'd0;
        end else begin
          cv_q[comp_q] <= acc_q;
          if (comp_q != 2'd2) begin
            comp_q <= comp_q + 2'd1;
            term_q <= tnt_pkg::term_e'(term_q + 4'd1);
          end
        end
      end
      tnt_pkg::ST_ABS: begin
        for (int i = 0; i < 3; i++) begin
          sg_q[i] <= cv_q[i][AccW-1];
          m_q[i]  <= cv_q[i][AccW-1] ? (~cv_q[i] + 1'b1) : cv_q[i];
        end
        uq_q[0] <= 16'd0;
        uq_q[1] <= 16'd0;
        uq_q[2] <= tnt_pkg::Q14_ONE;
        comp_q  <= 2'd0;
        len2_q  <= '0;
      end
      tnt_pkg::ST_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if ((or_m >> (tnt_pkg::NORM_W + 8)) != '0)   m_q[i] <= m_q[i] >> 8;
          else if ((or_m >> tnt_pkg::NORM_W) != '0)    m_q[i] <= m_q[i] >> 1;
          else if ((or_m >> (tnt_pkg::NORM_W - 9)) == '0) m_q[i] <= m_q[i] << 8;
          else if (!or_m[tnt_pkg::NORM_W-1])           m_q[i] <= m_q[i] << 1;
        end
      end
      tnt_pkg::ST_SQ_MUL: begin
        mul_q <= mul_a * mul_b;
      end
      tnt_pkg::ST_SQ_ACC: begin
        len2_q <= len2_q + tnt_pkg::SQ_W'(mul_q);
        n_q    <= len2_q + tnt_pkg::SQ_W'(mul_q);
        comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
        res_q  <= '0;
        bit_q  <= tnt_pkg::SQ_W'(1) << (tnt_pkg::SQ_W - 2);
      end
      tnt_pkg::ST_SQRT: begin
        if (n_q >= rt_trial) begin
          n_q   <= n_q - rt_trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      tnt_pkg::ST_DIV_INIT: begin
        rem_q  <= (tnt_pkg::DIV_W'(vsel) << (tnt_pkg::FRAC_W + 1))
                  + tnt_pkg::DIV_W'(res_q[tnt_pkg::LEN_W-1:0]);
        den_q  <= {res_q[tnt_pkg::LEN_W-1:0], 1'b0};
        quo_q  <= '0;
        iter_q <= 4'(tnt_pkg::FRAC_W);
      end
      tnt_pkg::ST_DIV: begin
        if (rem_q >= dv_trial) begin
          rem_q          <= rem_q - dv_trial;
          quo_q[iter_q]  <= 1'b1;
        end
        iter_q <= iter_q - 4'd1;
      end
      tnt_pkg::ST_DIV_END: begin
        uq_q[comp_q] <= q_signed;
        comp_q       <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
      end
      tnt_pkg::ST_UNIT: begin
        acc_q  <= '0;
        prod_q <= 1'b0;
        part_q <= 2'd0;
        comp_q <= 2'd0;
        case (vec_q)
          tnt_pkg::VEC_NORMAL: begin
            basis_q.normal_x <= uq_q[0];
            basis_q.normal_y <= uq_q[1];
            basis_q.normal_z <= uq_q[2];
            term_q           <= tnt_pkg::TERM_DET;
          end
          tnt_pkg::VEC_TANGENT: begin
            basis_q.tangent_x <= uq_q[0];
            basis_q.tangent_y <= uq_q[1];
            basis_q.tangent_z <= uq_q[2];
            term_q            <= tnt_pkg::TERM_BX;
            vec_q             <= tnt_pkg::VEC_BITANGENT;
          end
          default: begin
            basis_q.bitangent_x   <= uq_q[0];
            basis_q.bitangent_y   <= uq_q[1];
            basis_q.bitangent_z   <= uq_q[2];
            basis_q.tangent_valid <= 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/triangle_normal_tangent.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_normal_tangent
// Flat face normal and UV tangent basis of a triangle streamed one vertex
// at a time; unit vectors in signed Q1.14.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                  | payload
//  in      | in  | in_valid_i / in_ready_o    | in_data_i  (tnt_pkg::vertex_t)
//  out     | out | out_valid_o / out_ready_i  | out_data_o (tnt_pkg::basis_t)
//  cfg     | in  | cfg_valid_i / cfg_ready_o  | cfg_data_i (tangents_enable)
//
// The first and second vertex of a triangle are always accepted. The back
// end takes one triangle at a time, built on the shared 30x30 multiplier,
// the one-bit-pair square root and the one-bit restoring divider. The job
// queue holds two triangles, so vertices keep flowing while the back end or
// a stalled output holds. Reset clears the vertex count, queue, sequencer
// and tangents_enable.
// ----------------------------------------------------------------------------
module triangle_normal_tangent #(
  parameter int unsigned CoordWidth = tnt_pkg::COORD_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire tnt_pkg::vertex_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output tnt_pkg::basis_t       out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_data_i
);

  localparam int unsigned OpW  = CoordWidth + 1;
  localparam int unsigned JobW = tnt_pkg::NUM_OPS * OpW + 1;

  logic                                  tangents_enable_q;
  logic                                  push_valid, push_ready, pop_valid, pop_ready;
  logic [tnt_pkg::NUM_OPS-1:0][OpW-1:0]  front_ops, back_ops;
  logic                                  front_tan, back_tan;
  logic [JobW-1:0]                       pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tangents_enable_q <= 1'b0;
    end else if (cfg_valid_i) begin
      tangents_enable_q <= cfg_data_i;
    end
  end

  tnt_front #(.CoordWidth(CoordWidth)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_data_i         (in_data_i),
    .tangents_enable_i (tangents_enable_q),
    .job_valid_o       (push_valid),
    .job_ready_i       (push_ready),
    .job_ops_o         (front_ops),
    .job_tan_o         (front_tan)
  );

  tnt_queue #(.Width(JobW), .Depth(tnt_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({front_tan, front_ops}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign back_tan = pop_data[JobW-1];
  assign back_ops = pop_data[JobW-2:0];

  tnt_back #(.CoordWidth(CoordWidth)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_ops_i   (back_ops),
    .job_tan_i   (back_tan),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams triangle vertices through triangle_normal_tangent and checks each
// face normal and tangent basis against a bit-exact predictor, or against a
// fixed basis on the typed directed rows. A directed table covers the
// extremes and special cases, then random triangles run under several idle
// patterns, both tangent settings and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [63:0]  coord_t;

  typedef struct {
    tnt_pkg::vertex_t vtx;
    bit               typed;
    tnt_pkg::basis_t  want;
  } stim_row_t;

  localparam tnt_pkg::basis_t FLAT_DEFAULT = '{
    normal_x: 16'sd0, normal_y: 16'sd0, normal_z: tnt_pkg::Q14_ONE,
    tangent_x: tnt_pkg::Q14_ONE, tangent_y: 16'sd0, tangent_z: 16'sd0,
    bitangent_x: 16'sd0, bitangent_y: tnt_pkg::Q14_ONE, bitangent_z: 16'sd0,
    tangent_valid: 1'b0};
  localparam int DRAIN_CYCLES = 600;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  tnt_pkg::vertex_t in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  tnt_pkg::basis_t  out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_data = 1'b0;

  triangle_normal_tangent dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // predictor state
  coord_t held_pos [6];
  coord_t held_uv  [4];
  int     held_count = 0;
  bit     tangents_on = 1'b0;

  tnt_pkg::basis_t basis_q [$];
  stim_row_t       table_rows [$];
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     recv_hold = 0;
  int     mismatches = 0;
  int     triangles = 0;
  int     with_tangents = 0;
  int     flat_normals = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic wide_t cross_term(coord_t a, coord_t b, coord_t c, coord_t d);
    wide_t wa, wb, wc, wd;
    wa = a; wb = b; wc = c; wd = d;
    return wa * wb - wc * wd;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, bit_pos;
    res = 0;
    bit_pos = 64'd1 << 62;
    while (bit_pos > n) bit_pos = bit_pos >> 2;
    while (bit_pos != 0) begin
      if (n >= res + bit_pos) begin
        n = n - (res + bit_pos);
        res = (res >> 1) + bit_pos;
      end else begin
        res = res >> 1;
      end
      bit_pos = bit_pos >> 2;
    end
    return res;
  endfunction

  // returns {x, y, z} in Q1.14
  function automatic logic [47:0] unit_q14(wide_t cx, wide_t cy, wide_t cz);
    wide_t       c [3];
    logic [127:0] mag [3];
    logic [127:0] mag_or;
    logic [63:0]  v [3];
    logic [63:0]  len2, len, q;
    logic [15:0]  o [3];
    int           bl;
    c[0] = cx; c[1] = cy; c[2] = cz;
    mag_or = 0;
    len2 = 0;
    bl = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = c[i][127] ? -c[i] : c[i];
      mag_or |= mag[i];
    end
    if (mag_or == 0) return {16'd0, 16'd0, tnt_pkg::Q14_ONE};
    for (int k = 0; k < 128; k++) if (mag_or[k]) bl = k + 1;
    for (int i = 0; i < 3; i++) begin
      if (bl > 30) v[i] = 64'(mag[i] >> (bl - 30));
      else v[i] = mag[i][63:0] << (30 - bl);
      len2 += v[i] * v[i];
    end
    len = int_sqrt(len2);
    for (int i = 0; i < 3; i++) begin
      q = (v[i] * 64'd32768 + len) / (2 * len);
      o[i] = c[i][127] ? 16'(-q) : 16'(q);
    end
    return {o[0], o[1], o[2]};
  endfunction

  // advance the vertex state; returns 1 when a triangle completes
  function automatic bit predict_basis(tnt_pkg::vertex_t vin, output tnt_pkg::basis_t r);
    coord_t x, y, z, u, v, e1 [3], e2 [3], du1, dv1, du2, dv2;
    wide_t  det, t [3], b [3];
    x = vin.pos_x; y = vin.pos_y; z = vin.pos_z; u = vin.tex_u; v = vin.tex_v;
    r = FLAT_DEFAULT;
    if (held_count < 2) begin
      held_pos[held_count*3]   = x;
      held_pos[held_count*3+1] = y;
      held_pos[held_count*3+2] = z;
      held_uv[held_count*2]    = u;
      held_uv[held_count*2+1]  = v;
      held_count++;
      return 1'b0;
    end
    held_count = 0;
    for (int i = 0; i < 3; i++) e1[i] = held_pos[3+i] - held_pos[i];
    e2[0] = x - held_pos[0];
    e2[1] = y - held_pos[1];
    e2[2] = z - held_pos[2];
    {r.normal_x, r.normal_y, r.normal_z} = unit_q14(
      cross_term(e1[1], e2[2], e1[2], e2[1]),
      cross_term(e1[2], e2[0], e1[0], e2[2]),
      cross_term(e1[0], e2[1], e1[1], e2[0]));
    if (tangents_on && vin.has_uv) begin
      du1 = held_uv[2] - held_uv[0];
      dv1 = held_uv[3] - held_uv[1];
      du2 = u - held_uv[0];
      dv2 = v - held_uv[1];
      det = cross_term(du1, dv2, du2, dv1);
      if (det != 0) begin
        for (int i = 0; i < 3; i++) begin
          t[i] = cross_term(e1[i], dv2, e2[i], dv1);
          b[i] = cross_term(e2[i], du1, e1[i], du2);
          if (det[127]) begin
            t[i] = -t[i];
            b[i] = -b[i];
          end
        end
        {r.tangent_x, r.tangent_y, r.tangent_z} = unit_q14(t[0], t[1], t[2]);
        {r.bitangent_x, r.bitangent_y, r.bitangent_z} = unit_q14(b[0], b[1], b[2]);
        r.tangent_valid = 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic tnt_pkg::vertex_t mk_vertex(int x, int y, int z, int u, int v, bit uv);
    tnt_pkg::vertex_t r;
    r.pos_x = x; r.pos_y = y; r.pos_z = z; r.tex_u = u; r.tex_v = v; r.has_uv = uv;
    return r;
  endfunction

  function automatic void add_row(tnt_pkg::vertex_t vtx, bit typed, tnt_pkg::basis_t want);
    stim_row_t row;
    row.vtx   = vtx;
    row.typed = typed;
    row.want  = want;
    table_rows.insert(table_rows.size(), row);
  endfunction

  // hold valid across back-to-back transfers; drop it only while idling
  task automatic send_vertex(tnt_pkg::vertex_t vtx, bit typed, tnt_pkg::basis_t want);
    tnt_pkg::basis_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= vtx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_basis(vtx, pred)) basis_q.insert(basis_q.size(), typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic write_tangents(bit val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tangents_on = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    wait (basis_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int rand_coord(int style);
    case (style)
      0:       return $urandom_range(0, 2097151) - 1048576;
      1:       return $urandom;
      default: return $urandom_range(0, 63) - 32;
    endcase
  endfunction

  task automatic send_random_triangle;
    tnt_pkg::vertex_t v [3];
    int               style, kind;
    kind  = $urandom_range(99);
    style = (kind < 20) ? 1 : (kind < 30) ? 2 : 0;
    for (int i = 0; i < 3; i++)
      v[i] = mk_vertex(rand_coord(style), rand_coord(style), rand_coord(style),
                       rand_coord(style), rand_coord(style), $urandom_range(99) < 85);
    if (kind >= 90 && kind < 95) v[2] = v[$urandom_range(1)];
    if (kind >= 95) begin
      v[1].tex_u = v[0].tex_u; v[1].tex_v = v[0].tex_v;
      v[2].tex_u = v[0].tex_u; v[2].tex_v = v[0].tex_v;
    end
    for (int i = 0; i < 3; i++) send_vertex(v[i], 1'b0, FLAT_DEFAULT);
  endtask

  // result side: ready pattern and long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (recv_hold > 0) begin
        out_ready <= 1'b0;
        recv_hold--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    tnt_pkg::basis_t want;
    logic [144:0]    w, g;
    if (rst_n && out_valid && out_ready) begin
      if (basis_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = basis_q.pop_front();
        w = want;
        g = out_data;
        triangles++;
        if (want.tangent_valid) with_tangents++;
        if (want.normal_z == tnt_pkg::Q14_ONE && want.normal_x == 0 && want.normal_y == 0)
          flat_normals++;
        for (int i = 0; i < 10; i++) begin
          if ((i < 9) ? (w[144-16*i -: 16] !== g[144-16*i -: 16]) : (w[0] !== g[0])) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d field %0d: expected %h got %h", triangles, i,
                       (i < 9) ? w[144-16*i -: 16] : 16'(w[0]),
                       (i < 9) ? g[144-16*i -: 16] : 16'(g[0]));
          end
        end
      end
    end
  end

  initial begin
    tnt_pkg::basis_t unit_basis;
    int              plan_send [6];
    int              plan_recv [6];
    bit              plan_tan  [6];

    plan_send = '{15, 15, 87, 87, 0, 0};
    plan_recv = '{87, 87, 15, 15, 0, 0};
    plan_tan  = '{1, 0, 1, 0, 1, 0};

    unit_basis = FLAT_DEFAULT;
    unit_basis.tangent_valid = 1'b1;

    // all-zero triangle: flat normal, zero determinant
    for (int i = 0; i < 3; i++) add_row(mk_vertex(0, 0, 0, 0, 0, 1), 1'b1, FLAT_DEFAULT);
    // unit right triangle with matching UVs
    add_row(mk_vertex(0, 0, 0, 0, 0, 1), 1'b0, FLAT_DEFAULT);
    add_row(mk_vertex(65536, 0, 0, 65536, 0, 1), 1'b0, FLAT_DEFAULT);
    add_row(mk_vertex(0, 65536, 0, 0, 65536, 1), 1'b1, unit_basis);
    // coordinate extremes
    add_row(mk_vertex(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h80000000, 32'h80000000, 1), 1'b0, FLAT_DEFAULT);
    add_row(mk_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                      32'h7fffffff, 32'h80000000, 1), 1'b0, FLAT_DEFAULT);
    add_row(mk_vertex(32'h80000000, 32'h7fffffff, 32'h7fffffff,
                      32'h80000000, 32'h7fffffff, 1), 1'b0, FLAT_DEFAULT);
    // repeated UVs: zero determinant
    add_row(mk_vertex(0, 0, 0, 7, 9, 1), 1'b0, FLAT_DEFAULT);
    add_row(mk_vertex(65536, 0, 0, 7, 9, 1), 1'b0, FLAT_DEFAULT);
    add_row(mk_vertex(0, 65536, 0, 7, 9, 1), 1'b1, FLAT_DEFAULT);
    // no UVs on the closing vertex
    add_row(mk_vertex(0, 0, 0, 0, 0, 1), 1'b0, FLAT_DEFAULT);
    add_row(mk_vertex(65536, 0, 0, 65536, 0, 1), 1'b0, FLAT_DEFAULT);
    add_row(mk_vertex(0, 65536, 0, 0, 65536, 0), 1'b1, FLAT_DEFAULT);
    // collinear edges: zero tangent vector with nonzero determinant
    add_row(mk_vertex(0, 0, 0, 0, 0, 1), 1'b0, FLAT_DEFAULT);
    add_row(mk_vertex(65536, 0, 0, 65536, 65536, 1), 1'b0, FLAT_DEFAULT);
    add_row(mk_vertex(131072, 0, 0, 0, 131072, 1), 1'b0, FLAT_DEFAULT);
    // negative determinant, skewed triangle
    add_row(mk_vertex(-300000, 12345, 99999, 0, 0, 1), 1'b0, FLAT_DEFAULT);
    add_row(mk_vertex(5000, -70000, 3, 0, 65536, 1), 1'b0, FLAT_DEFAULT);
    add_row(mk_vertex(1, 2, -900000, 65536, 0, 1), 1'b0, FLAT_DEFAULT);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_tangents(1'b1);
    send_idle_pct = 30;
    recv_idle_pct = 30;
    foreach (table_rows[i]) send_vertex(table_rows[i].vtx, table_rows[i].typed, table_rows[i].want);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_tangents(plan_tan[p]);
      send_idle_pct = plan_send[p];
      recv_idle_pct = plan_recv[p];
      if (p == 4) recv_hold = 3000;
      for (int n = 0; n < 79; n++) send_random_triangle();
      drain();
    end

    $display("covered %0d triangles: %0d with a computed tangent basis, %0d flat normals",
             triangles, with_tangents, flat_normals);
    $display("idle patterns 15/87, 87/15 and none, tangents on and off, one long stall");
    if (mismatches == 0 && basis_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
